FILE: src/mfmd_pkg.sv
// ----------------------------------------------------------------------------
// mfmd_pkg
// Shared types and constants of the motor feedback multiturn decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

    localparam int MOTOR_COUNT   = 4;
    localparam int IDX_W         = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int ID_W          = 11;
    localparam int WORD_W        = 16;
    localparam int TEMP_W        = 8;
    localparam int TURN_W        = 32;
    localparam int ANGLE_SHIFT   = 13;
    localparam int TOTAL_W       = TURN_W + ANGLE_SHIFT + 1;
    localparam int MOTOR_INDEX_W = 2;
    localparam int DIFF_W        = WORD_W + 1;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(4096);
    localparam logic [ID_W-1:0] FIRST_ID_RESET = ID_W'(513);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int IN_DATA_BITS  = ID_W + 3 * WORD_W + TEMP_W;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 3 * WORD_W + TEMP_W + TURN_W + TOTAL_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    // One classified frame, as it waits between front and back
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] angle;
        logic [WORD_W-1:0] speed;
        logic [WORD_W-1:0] current;
        logic [TEMP_W-1:0] temp;
    } t_frame;

    // One decoded result
    typedef struct packed {
        logic [MOTOR_INDEX_W-1:0] motor_index;
        logic [WORD_W-1:0]        angle;
        logic [WORD_W-1:0]        speed;
        logic [WORD_W-1:0]        current;
        logic [TEMP_W-1:0]        temp;
        logic signed [TURN_W-1:0] turns;
        logic signed [TOTAL_W-1:0] total;
    } t_result;

    // Mask or widen a motor slot number to the reported index width
    function automatic logic [MOTOR_INDEX_W-1:0] to_motor_index(input logic [IDX_W-1:0] idx);
        logic [MOTOR_INDEX_W+IDX_W-1:0] ext;
        ext = {{MOTOR_INDEX_W{1'b0}}, idx};
        return ext[MOTOR_INDEX_W-1:0];
    endfunction

endpackage

FILE: src/motor_feedback_multiturn_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder
// Decode motor feedback frames and track each motor's multiturn angle.
// ----------------------------------------------------------------------------
// Path: an accepted frame passes the queue, then the turn-count stage, then the
//   total-angle output register.
// Throughput: one frame per cycle unless stalled; the per-motor compare and add
//   run in a single back-end stage, and the 4-entry queue absorbs output stalls.
// Reset: synchronous, active low; clears angles and turn counts of every motor,
//   empties the queue and pipeline, and loads first_motor_id with 513.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder import mfmd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration: first_motor_id
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [ID_W-1:0]        i_cfg_data,

    // Frame input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: frame_id[10:0], angle_word[26:11], speed_word[42:27],
    //        current_word[58:43], temperature_byte[66:59], zero pad above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: from_first_bus
    input  logic                   s_axis_tuser,

    // Result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: rotor_angle[15:0], rotor_speed[31:16], coil_current[47:32],
    //        motor_temperature[55:48], turn_count[87:56], accum_angle[133:88],
    //        zero pad above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: motor_index
    output logic [MOTOR_INDEX_W-1:0] m_axis_tuser
);

    logic [ID_W-1:0] r_first_id;

    logic    s_accept;
    logic    push;
    t_frame  push_frame;
    logic    q_full;
    logic    q_valid;
    t_frame  q_frame;
    logic    pop;
    t_result result;

    // Configuration register; writes must arrive only while idle, the block does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id <= FIRST_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_first_id <= i_cfg_data;
        end
    end

    // Hold the input only when the queue is full, frames that will be dropped included
    assign s_axis_tready = !q_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    mfmd_front u_front (
        .i_accept         (s_accept),
        .i_from_first_bus (s_axis_tuser),
        .i_frame_id       (s_axis_tdata[ID_W-1:0]),
        .i_angle          (s_axis_tdata[ID_W +: WORD_W]),
        .i_speed          (s_axis_tdata[ID_W+WORD_W +: WORD_W]),
        .i_current        (s_axis_tdata[ID_W+2*WORD_W +: WORD_W]),
        .i_temp           (s_axis_tdata[ID_W+3*WORD_W +: TEMP_W]),
        .i_first_id       (r_first_id),
        .o_push           (push),
        .o_frame          (push_frame)
    );

    mfmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_frame (q_frame)
    );

    mfmd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_frame  (q_frame),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .o_result (result),
        .i_ready  (m_axis_tready)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tuser = result.motor_index;
    assign m_axis_tdata = OUT_TDATA_W'({result.total, result.turns, result.temp,
                                        result.current, result.speed, result.angle});

    // Low bits of the total angle always match the rotor angle
    a_total_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (result.total[ANGLE_SHIFT-1:0] == result.angle[ANGLE_SHIFT-1:0]))
        else $error("accum_angle low bits disagree with rotor_angle");

    // Only accepted motor-bus frames enter the queue
    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (s_axis_tvalid && s_axis_tready && s_axis_tuser))
        else $error("frame queued without an accepted motor-bus transaction");

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: src/mfmd_front.sv
// ----------------------------------------------------------------------------
// mfmd_front
// Classify incoming frames: keep motor-bus frames inside the ID window.
// ----------------------------------------------------------------------------
module mfmd_front import mfmd_pkg::*; (
    input  logic              i_accept,
    input  logic              i_from_first_bus,
    input  logic [ID_W-1:0]   i_frame_id,
    input  logic [WORD_W-1:0] i_angle,
    input  logic [WORD_W-1:0] i_speed,
    input  logic [WORD_W-1:0] i_current,
    input  logic [TEMP_W-1:0] i_temp,
    input  logic [ID_W-1:0]   i_first_id,
    output logic              o_push,
    output t_frame            o_frame
);

    logic [ID_W:0]   id_ext;
    logic [ID_W:0]   lo_id;
    logic [ID_W:0]   hi_id;
    logic [ID_W-1:0] offset;
    logic            hit;

    // Window is not wrapped past the top identifier
    assign id_ext = {1'b0, i_frame_id};
    assign lo_id  = {1'b0, i_first_id};
    assign hi_id  = lo_id + (ID_W+1)'(MOTOR_COUNT - 1);
    assign hit    = i_from_first_bus && (id_ext >= lo_id) && (id_ext <= hi_id);
    assign offset = i_frame_id - i_first_id;

    assign o_push          = i_accept && hit;
    assign o_frame.idx     = offset[IDX_W-1:0];
    assign o_frame.angle   = i_angle;
    assign o_frame.speed   = i_speed;
    assign o_frame.current = i_current;
    assign o_frame.temp    = i_temp;

endmodule

FILE: src/mfmd_queue.sv
// ----------------------------------------------------------------------------
// mfmd_queue
// Short frame queue between the classifier and the tracking back end.
// ----------------------------------------------------------------------------
module mfmd_queue import mfmd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_frame o_frame
);

    t_frame            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/mfmd_back.sv
// ----------------------------------------------------------------------------
// mfmd_back
// Per-motor angle tracking, turn counting and result register.
// ----------------------------------------------------------------------------
module mfmd_back import mfmd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_frame  i_frame,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic [WORD_W-1:0]        r_angle [MOTOR_COUNT];
    logic signed [TURN_W-1:0] r_turns [MOTOR_COUNT];

    logic                     r_s1_valid;
    t_frame                   r_s1_frame;
    logic signed [TURN_W-1:0] r_s1_turns;

    logic                     r_o_valid;
    t_result                  r_result;

    logic                     out_ready;
    logic                     s1_ready;
    logic signed [DIFF_W-1:0] diff;
    logic signed [TURN_W-1:0] n_turns;
    logic [TOTAL_W-1:0]       n_total;

    assign out_ready = !r_o_valid || i_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_pop     = i_valid && s1_ready;

    // Signed jump between new and stored angle over full 16-bit words
    assign diff = $signed({1'b0, i_frame.angle}) - $signed({1'b0, r_angle[i_frame.idx]});

    always_comb begin
        n_turns = r_turns[i_frame.idx];
        if (diff > HALF_TURN) begin
            n_turns = r_turns[i_frame.idx] - TURN_W'(1);
        end else if (diff < -HALF_TURN) begin
            n_turns = r_turns[i_frame.idx] + TURN_W'(1);
        end
    end

    // turns * 8192 + angle, exact at full width
    assign n_total = {r_s1_turns[TURN_W-1], r_s1_turns, {ANGLE_SHIFT{1'b0}}}
                   + TOTAL_W'(r_s1_frame.angle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_angle[k] <= '0;
                r_turns[k] <= '0;
            end
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_angle[i_frame.idx] <= i_frame.angle;
                r_turns[i_frame.idx] <= n_turns;
            end
            if (s1_ready) begin
                r_s1_valid <= o_pop;
            end
            if (out_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_frame <= i_frame;
            r_s1_turns <= n_turns;
        end
        if (out_ready && r_s1_valid) begin
            r_result.motor_index <= to_motor_index(r_s1_frame.idx);
            r_result.angle       <= r_s1_frame.angle;
            r_result.speed       <= r_s1_frame.speed;
            r_result.current     <= r_s1_frame.current;
            r_result.temp        <= r_s1_frame.temp;
            r_result.turns       <= r_s1_turns;
            r_result.total       <= $signed(n_total);
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_result;

endmodule

FILE: sim/motor_feedback_multiturn_decoder_tb.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_tb
// Self-checking bench: drives CAN feedback frames through the stream input,
// tracks every motor's angle and turn count in a local model, and compares
// each decoded result field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder_tb import mfmd_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 3;
    localparam int DRAIN_CYCLES   = 8;    // margin for the pipeline to settle
    localparam int IDLE_LIMIT     = 2000; // cycles without any transaction
    localparam int LONG_HOLD      = 200;  // long receiver stall
    localparam int FILL_BURST     = 24;   // back-to-back frames offered during the stall
    localparam int HITS_PER_PHASE = 200;
    localparam int MAX_PRINTED    = 200;
    localparam int HALF_REV       = 4096;
    localparam int FULL_REV       = 8192;

    typedef struct {
        bit                bus;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] angle;
        logic [WORD_W-1:0] speed;
        logic [WORD_W-1:0] current;
        logic [TEMP_W-1:0] temp;
    } t_can_frame;

    // How a directed row is checked; a config row carries the new first ID in frm.id
    typedef enum {ROW_TYPED, ROW_PREDICT, ROW_DROPPED, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        t_can_frame               frm;
        logic [MOTOR_INDEX_W-1:0] idx;
        logic signed [TURN_W-1:0] turns;
        logic signed [TOTAL_W-1:0] total;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [ID_W-1:0]          i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // tdata: frame_id, angle_word, speed_word, current_word, temperature_byte, zero pad
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    // tuser: from_first_bus
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // tdata: rotor_angle, rotor_speed, coil_current, motor_temperature,
    //        turn_count, accum_angle, zero pad
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    // tuser: motor_index
    logic [MOTOR_INDEX_W-1:0] m_axis_tuser;

    // Local copy of the decoder state
    logic [ID_W-1:0]          first_id;
    logic [WORD_W-1:0]        motor_angle [MOTOR_COUNT];
    logic signed [TURN_W-1:0] motor_turns [MOTOR_COUNT];

    t_result pending_feedback[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;
    bit      hold_request = 1'b0;
    bit      src_steady = 1'b0;
    bit      sink_steady = 1'b0;

    motor_feedback_multiturn_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 55) return 0;
        if (roll < 85) return int'($urandom_range(1, 3));
        if (roll < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Decode one frame against the local state; return 1 when it yields a result.
    // Frames off the motor bus or outside the ID window leave the state untouched.
    function automatic bit decode_frame(input t_can_frame f, output t_result r);
        int                       slot;
        int                       delta;
        logic signed [TURN_W-1:0] turns;
        longint                   total;
        r = '0;
        if (!f.bus) return 1'b0;
        // window is not wrapped past the top identifier
        if (int'(f.id) < int'(first_id) || int'(f.id) > int'(first_id) + MOTOR_COUNT - 1)
            return 1'b0;
        slot = int'(f.id) - int'(first_id);
        delta = int'(f.angle) - int'(motor_angle[slot]);
        motor_angle[slot] = f.angle;
        // a jump over half a turn means the angle wrapped the other way
        if (delta > HALF_REV) begin
            motor_turns[slot] = motor_turns[slot] - 1;
        end else if (delta < -HALF_REV) begin
            motor_turns[slot] = motor_turns[slot] + 1;
        end
        turns = motor_turns[slot];
        total = longint'(turns) * FULL_REV + longint'(f.angle);
        r.motor_index = MOTOR_INDEX_W'(slot);
        r.angle = f.angle;
        r.speed = f.speed;
        r.current = f.current;
        r.temp = f.temp;
        r.turns = turns;
        r.total = TOTAL_W'(total);
        return 1'b1;
    endfunction

    // Mostly in-window frames whose angle walks around the turn, so turn counts
    // move both ways; the rest is other buses, stray IDs and IDs just off the window.
    function automatic t_can_frame random_frame();
        t_can_frame f;
        int         roll;
        int         span;
        int         slot;
        int         step;
        roll = int'($urandom_range(0, 99));
        span = 2047 - int'(first_id);
        if (span > MOTOR_COUNT - 1) span = MOTOR_COUNT - 1;
        slot = int'($urandom_range(0, span));
        f.bus = 1'b1;
        f.id = ID_W'(int'(first_id) + slot);
        f.angle = 16'($urandom);
        f.speed = 16'($urandom);
        f.current = 16'($urandom);
        f.temp = 8'($urandom);
        if (roll < 8) begin
            f.bus = 1'b0;
            if ($urandom_range(0, 1) == 1) f.id = 11'($urandom);
        end else if (roll < 16) begin
            f.id = 11'($urandom);
        end else if (roll < 24) begin
            f.id = ($urandom_range(0, 1) == 1) ? ID_W'(int'(first_id) - 1)
                                               : ID_W'(int'(first_id) + MOTOR_COUNT);
        end else if (roll < 66) begin
            step = int'($urandom_range(0, 6000)) - 3000;
            f.angle = 16'((int'(motor_angle[slot][12:0]) + step) & (FULL_REV - 1));
        end
        return f;
    endfunction

    function automatic t_stim_row mk_row(input t_row_kind kind, input bit bus, input int id,
                                         input int angle, input int speed, input int current,
                                         input int temp, input int idx, input int turns,
                                         input longint total);
        t_stim_row row;
        row.kind = kind;
        row.frm.bus = bus;
        row.frm.id = ID_W'(id);
        row.frm.angle = WORD_W'(angle);
        row.frm.speed = WORD_W'(speed);
        row.frm.current = WORD_W'(current);
        row.frm.temp = TEMP_W'(temp);
        row.idx = MOTOR_INDEX_W'(idx);
        row.turns = TURN_W'(turns);
        row.total = TOTAL_W'(total);
        return row;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            if (error_count < MAX_PRINTED)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Offer one frame, predict it at its transaction, then rest the sender
    task automatic play_frame(input t_can_frame f, input t_row_kind kind,
                              input t_result typed, output bit hit);
        t_result r;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f.bus;
        s_axis_tdata <= IN_TDATA_W'({f.temp, f.current, f.speed, f.angle, f.id});
        do @(posedge i_clk); while (!s_axis_tready);
        hit = decode_frame(f, r);
        if (kind == ROW_TYPED) begin
            pending_feedback.push_back(typed);
        end else if (kind == ROW_PREDICT && hit) begin
            pending_feedback.push_back(r);
        end
        gap = (burst_left > 0 || src_steady) ? 0 : pick_gap();
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_feedback.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_first_id(input logic [ID_W-1:0] value);
        drain_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        first_id = value;
    endtask

    // Receiver: random ready gaps, steady stretches, and a long stall on request
    initial begin : sink
        int gap_left;
        int hold_left;
        int mode_cycles;
        gap_left = 0;
        hold_left = 0;
        mode_cycles = 0;
        forever begin
            @(posedge i_clk);
            mode_cycles++;
            if (mode_cycles >= 150) begin
                mode_cycles = 0;
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                gap_left = sink_steady ? 0 : pick_gap();
            end
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.motor_index = m_axis_tuser;
            {got.total, got.turns, got.temp, got.current, got.speed, got.angle} =
                m_axis_tdata[OUT_DATA_BITS-1:0];
            if (pending_feedback.size() == 0) begin
                if (error_count < MAX_PRINTED)
                    $error("result with nothing expected: motor_index %0d, angle 0x%0h",
                           got.motor_index, got.angle);
                error_count++;
            end else begin
                want = pending_feedback.pop_front();
                check_field("motor_index", 64'(want.motor_index), 64'(got.motor_index));
                check_field("rotor_angle", 64'(want.angle), 64'(got.angle));
                check_field("rotor_speed", 64'(want.speed), 64'(got.speed));
                check_field("coil_current", 64'(want.current), 64'(got.current));
                check_field("motor_temperature", 64'(want.temp), 64'(got.temp));
                check_field("turn_count", 64'(unsigned'(want.turns)),
                            64'(unsigned'(got.turns)));
                check_field("accum_angle", 64'(unsigned'(want.total)),
                            64'(unsigned'(got.total)));
            end
        end
    end

    // Watchdog: end the run when no transaction of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_stim_row  rows[$];
        t_result    typed;
        bit         hit;
        int         hits;
        int         sent;
        int         bases[6];
        t_can_frame f;

        first_id = FIRST_ID_RESET;
        foreach (motor_angle[k]) begin
            motor_angle[k] = '0;
            motor_turns[k] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, window at reset (513..516); turn and total typed where obvious
        //                 kind         bus  id   angle  speed  curr   temp idx turns total
        rows.push_back(mk_row(ROW_TYPED,   1, 513, 0,     0,     0,     0,   0, 0,  0));
        // jump up by more than half a turn: one turn back
        rows.push_back(mk_row(ROW_TYPED,   1, 513, 5000,  'hFFFF, 0,    'hFF, 0, -1, -3192));
        rows.push_back(mk_row(ROW_TYPED,   1, 513, 0,     0,     'hFFFF, 0,  0, 0,  0));
        // other bus, and IDs just below and above the window
        rows.push_back(mk_row(ROW_DROPPED, 0, 513, 1234,  1,     2,     3,   0, 0,  0));
        rows.push_back(mk_row(ROW_DROPPED, 1, 512, 1234,  1,     2,     3,   0, 0,  0));
        rows.push_back(mk_row(ROW_DROPPED, 1, 517, 1234,  1,     2,     3,   0, 0,  0));
        // full-word extremes of every payload field
        rows.push_back(mk_row(ROW_TYPED,   1, 516, 'hFFFF, 'hFFFF, 'hFFFF, 'hFF, 3, -1, 57343));
        rows.push_back(mk_row(ROW_TYPED,   1, 516, 0,     0,     0,     0,   3, 0,  0));
        // exactly half a turn either way does not count
        rows.push_back(mk_row(ROW_TYPED,   1, 514, 4096,  0,     0,     0,   1, 0,  4096));
        rows.push_back(mk_row(ROW_TYPED,   1, 514, 0,     0,     0,     0,   1, 0,  0));
        rows.push_back(mk_row(ROW_TYPED,   1, 514, 4097,  0,     0,     0,   1, -1, -4095));
        rows.push_back(mk_row(ROW_TYPED,   1, 514, 8191,  0,     0,     0,   1, -1, -1));
        rows.push_back(mk_row(ROW_TYPED,   1, 515, 'hF000, 0,    0,     0,   2, -1, 53248));
        rows.push_back(mk_row(ROW_PREDICT, 1, 515, 'h5555, 'hAAAA, 'h5555, 'h55, 0, 0, 0));
        rows.push_back(mk_row(ROW_PREDICT, 1, 515, 'hAAAA, 'h5555, 'hAAAA, 'hAA, 0, 0, 0));
        rows.push_back(mk_row(ROW_DROPPED, 1, 2047, 7,    7,     7,     7,   0, 0,  0));
        rows.push_back(mk_row(ROW_DROPPED, 0, 0,   7,     7,     7,     7,   0, 0,  0));
        // window at the top of the ID range: only 2046 and 2047, no wrap to 0 and 1
        rows.push_back(mk_row(ROW_CONFIG,  0, 2046, 0,    0,     0,     0,   0, 0,  0));
        rows.push_back(mk_row(ROW_PREDICT, 1, 2046, 100,  11,    12,    13,  0, 0,  0));
        rows.push_back(mk_row(ROW_PREDICT, 1, 2047, 9000, 21,    22,    23,  0, 0,  0));
        rows.push_back(mk_row(ROW_DROPPED, 1, 0,    9000, 31,    32,    33,  0, 0,  0));
        rows.push_back(mk_row(ROW_DROPPED, 1, 1,    9000, 41,    42,    43,  0, 0,  0));

        foreach (rows[n]) begin
            if (rows[n].kind == ROW_CONFIG) begin
                set_first_id(rows[n].frm.id);
            end else begin
                typed.motor_index = rows[n].idx;
                typed.angle = rows[n].frm.angle;
                typed.speed = rows[n].frm.speed;
                typed.current = rows[n].frm.current;
                typed.temp = rows[n].frm.temp;
                typed.turns = rows[n].turns;
                typed.total = rows[n].total;
                play_frame(rows[n].frm, rows[n].kind, typed, hit);
            end
        end

        // Random phases, each with its own window base, extremes included
        bases = '{0, 2044, 2047, int'($urandom_range(1, 2043)), 513,
                  int'($urandom_range(1, 2043))};
        foreach (bases[p]) begin
            set_first_id(ID_W'(bases[p]));
            hits = 0;
            sent = 0;
            while (hits < HITS_PER_PHASE) begin
                if (sent % 80 == 0) src_steady = ($urandom_range(0, 3) == 0);
                // stall the receiver long while frames keep coming: fill up the queue
                if (sent == 40 && (p == 1 || p == 4)) begin
                    hold_request = 1'b1;
                    burst_left = FILL_BURST;
                end
                // hold the sender until every result is out
                if (sent == 150) drain_idle();
                f = random_frame();
                play_frame(f, ROW_PREDICT, '0, hit);
                hits += int'(hit);
                sent++;
            end
        end

        drain_idle();
        if (error_count == 0 && pending_feedback.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/mfmd_pkg.sv
src/mfmd_front.sv
src/mfmd_queue.sv
src/mfmd_back.sv
src/motor_feedback_multiturn_decoder.sv
sim/motor_feedback_multiturn_decoder_tb.sv
